@@ sv/pst_pkg.sv @@
// Shared constants, codes and types for the postfix stack evaluator.
package pst_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = 11;
	localparam int WORD_W      = 32;
	localparam int VAL_W       = 31;
	localparam int KIND_W      = 3;
	localparam int STAT_W      = 3;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = 6;

	localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SUB     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MUL     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DIV     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_END     = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STAT_W-1:0] STAT_UNDER = 3'd1;
	localparam logic [STAT_W-1:0] STAT_OVER  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DIVZ  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd4;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

@@ sv/postfix_stack_evaluator.sv @@
// Postfix evaluator top level: token sequencer, top-of-stack register, result register.
// Operand, end, ignored and underflowing tokens go idle to finish; add, subtract,
// multiply and divide by zero pass through operate, divide also through divide wait.
// One token in flight, taken once the result commits; output stalls hold finish.
// Stack entries below the top live in a 1024-word RAM with a registered read on accept.
// Reset clears the state machine, stack count and output valid; RAM is not cleared.
module postfix_stack_evaluator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pst_pkg::KIND_W-1:0]  kind,
	input  logic [pst_pkg::VAL_W-1:0]   operand_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [pst_pkg::WORD_W-1:0] top_value,
	output logic [pst_pkg::CNT_W-1:0]   depth,
	output logic [pst_pkg::STAT_W-1:0]  status,
	output logic                        final_res
);
	import pst_pkg::*;

	state_t              state_q, state_nxt;
	logic [CNT_W-1:0]    count_q;
	word_t               top_q;
	logic                out_valid_q;
	logic                divz_q;
	logic [KIND_W-1:0]   kind_q;
	logic [VAL_W-1:0]    val_q;
	word_t               res_q;
	word_t               out_top_q;
	logic [CNT_W-1:0]    out_depth_q;
	logic [STAT_W-1:0]   out_stat_q;
	logic                out_fin_q;

	logic                accept;
	logic                commit;
	logic                div_start;
	logic                div_done;
	word_t               div_quo;
	logic                is_op;
	word_t               rdata;
	logic                mem_we;

	word_t               nxt_top;
	logic [CNT_W-1:0]    nxt_count;
	logic [STAT_W-1:0]   nxt_stat;
	logic                nxt_fin;
	word_t               rep_top;

	assign accept = in_valid && in_ready;
	assign is_op  = (kind >= KIND_ADD) && (kind <= KIND_DIV);

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = (is_op && count_q >= CNT_W'(2)) ? ST_OP : ST_FIN;
				end
			end
			ST_OP: begin
				if (kind_q == KIND_DIV && top_q != '0) begin
					div_start = 1'b1;
					state_nxt = ST_DIV;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					commit    = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		nxt_top   = top_q;
		nxt_count = count_q;
		nxt_stat  = STAT_OK;
		nxt_fin   = 1'b0;
		mem_we    = 1'b0;
		unique case (kind_q) inside
			KIND_OPERAND: begin
				if (count_q >= CNT_W'(STACK_DEPTH)) begin
					nxt_stat = STAT_OVER;
				end else begin
					nxt_top   = {1'b0, val_q};
					nxt_count = count_q + CNT_W'(1);
					mem_we    = commit && (count_q != '0);
				end
			end
			KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
				if (count_q < CNT_W'(2)) begin
					nxt_stat = STAT_UNDER;
				end else if (divz_q) begin
					nxt_stat = STAT_DIVZ;
				end else begin
					nxt_top   = res_q;
					nxt_count = count_q - CNT_W'(1);
				end
			end
			KIND_END: begin
				nxt_fin = 1'b1;
				if (count_q == '0) begin
					nxt_stat = STAT_EMPTY;
				end else begin
					nxt_count = '0;
				end
			end
			default: ;
		endcase
		if (kind_q == KIND_END) begin
			rep_top = (count_q == '0) ? '0 : top_q;
		end else begin
			rep_top = (nxt_count == '0) ? '0 : nxt_top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			divz_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				divz_q <= 1'b0;
			end else if (state_q == ST_OP) begin
				divz_q <= (kind_q == KIND_DIV) && (top_q == '0);
			end
			if (commit) begin
				count_q     <= nxt_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			val_q  <= operand_value;
		end
		if (state_q == ST_OP) begin
			case (kind_q)
				KIND_ADD: res_q <= rdata + top_q;
				KIND_SUB: res_q <= rdata - top_q;
				KIND_MUL: res_q <= rdata * top_q;
				default:  res_q <= res_q;
			endcase
		end else if (state_q == ST_DIV && div_done) begin
			res_q <= div_quo;
		end
		if (commit) begin
			top_q       <= nxt_top;
			out_top_q   <= rep_top;
			out_depth_q <= nxt_count;
			out_stat_q  <= nxt_stat;
			out_fin_q   <= nxt_fin;
		end
	end

	pst_stack_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ADDR_W'(count_q - CNT_W'(1))),
		.wdata (top_q),
		.re    (accept),
		.raddr (ADDR_W'(count_q - CNT_W'(2))),
		.rdata (rdata)
	);

	pst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rdata),
		.den    (top_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign out_valid = out_valid_q;
	assign top_value = $signed(out_top_q);
	assign depth     = out_depth_q;
	assign status    = out_stat_q;
	assign final_res = out_fin_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide wait");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second beat taken while token in flight");

	a_final_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_res |-> depth == '0)
		else $error("end of expression left entries on stack");
`endif

endmodule

@@ sv/pst_stack_mem.sv @@
// Operand stack storage: one write port, one registered read port.
module pst_stack_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [pst_pkg::ADDR_W-1:0] waddr,
	input  pst_pkg::word_t            wdata,
	input  logic                      re,
	input  logic [pst_pkg::ADDR_W-1:0] raddr,
	output pst_pkg::word_t            rdata
);
	import pst_pkg::*;

	word_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/pst_div.sv @@
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
module pst_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pst_pkg::word_t num,
	input  pst_pkg::word_t den,
	output logic           done,
	output pst_pkg::word_t quo
);
	import pst_pkg::*;

	logic                 active_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	word_t                rem_q;
	word_t                q_q;
	word_t                d_q;
	logic                 neg_q;
	logic [WORD_W:0]      rem_sh;
	logic [WORD_W:0]      rem_sub;

	assign rem_sh  = {rem_q, q_q[WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= DIV_CNT_W'(DIV_STEPS);
			end else if (active_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num[WORD_W-1] ? (word_t'(0) - num) : num;
			d_q   <= den[WORD_W-1] ? (word_t'(0) - den) : den;
			neg_q <= num[WORD_W-1] ^ den[WORD_W-1];
		end else if (active_q) begin
			if (!rem_sub[WORD_W]) begin
				rem_q <= rem_sub[WORD_W-1:0];
				q_q   <= {q_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[WORD_W-1:0];
				q_q   <= {q_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? (word_t'(0) - q_q) : q_q;

endmodule
